// ===== hdl/vip_pkg.sv =====
package vip_pkg;

    localparam int QBITS = 50;
    localparam int FBITS = 16;
    localparam int DBITS = 50;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] efield_x;
        logic signed [31:0] efield_y;
        logic signed [31:0] efield_z;
        logic signed [31:0] bfield_x;
        logic signed [31:0] bfield_y;
        logic signed [31:0] bfield_z;
        logic               batch_end;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               last_out;
        logic               saturated;
    } t_out_item;

    function automatic logic signed [47:0] rnd(input logic signed [63:0] p);
        logic signed [63:0] y;
        y = p + 64'sd32768;
        return y[63:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [52:0] x);
        if (x > 53'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -53'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== hdl/vip_qdiv.sv =====
module vip_qdiv (
    input  logic                        i_clk,
    input  logic [vip_pkg::QBITS-1:0]   i_mag,
    input  logic [vip_pkg::DBITS-1:0]   i_den,
    output logic [vip_pkg::QBITS-1:0]   o_quo
);

    localparam int QB = vip_pkg::QBITS;
    localparam int FB = vip_pkg::FBITS;
    localparam int DW = vip_pkg::DBITS;

    logic [DW-1:0] r_rem [QB];
    logic [QB-1:0] r_quo [QB];
    logic [QB-1:0] r_mag [QB];
    logic [DW-1:0] r_den [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            localparam int BITPOS = QB - 1 - k;
            logic [DW-1:0] w_rem;
            logic [QB-1:0] w_quo;
            logic [QB-1:0] w_mag;
            logic [DW-1:0] w_den;
            logic          w_nb;
            logic [DW:0]   n_sh;
            if (k == 0) begin : g_first
                assign w_rem = DW'(i_mag[QB-1 -: FB]);
                assign w_quo = '0;
                assign w_mag = i_mag;
                assign w_den = i_den;
            end else begin : g_next
                assign w_rem = r_rem[k-1];
                assign w_quo = r_quo[k-1];
                assign w_mag = r_mag[k-1];
                assign w_den = r_den[k-1];
            end
            if (BITPOS >= FB) begin : g_bit
                assign w_nb = w_mag[BITPOS-FB];
            end else begin : g_zero
                assign w_nb = 1'b0;
            end
            assign n_sh = {w_rem, w_nb};
            always_ff @(posedge i_clk) begin
                if (n_sh >= {1'b0, w_den}) begin
                    r_rem[k] <= DW'(n_sh - {1'b0, w_den});
                    r_quo[k] <= {w_quo[QB-2:0], 1'b1};
                end else begin
                    r_rem[k] <= DW'(n_sh);
                    r_quo[k] <= {w_quo[QB-2:0], 1'b0};
                end
                r_mag[k] <= w_mag;
                r_den[k] <= w_den;
            end
        end
    endgenerate

    assign o_quo = r_quo[QB-1];

endmodule

// ===== hdl/implicit_particle_velocity_push_top.sv =====
// Pipeline: an accepted item passes six arithmetic stages, a 50-stage restoring divider
// per component and an output register before its result strobe.
// Throughput: one item per cycle; busy stays low since results cannot be stalled.
// Reset is synchronous and active low; it clears the valid bits and sets the
// half charge step register to zero.
module implicit_particle_velocity_push_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  vip_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output vip_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    localparam int QB = vip_pkg::QBITS;
    localparam int DW = vip_pkg::DBITS;

    logic signed [31:0] r_beta;
    logic [5:0]         r_vld;
    logic [QB-1:0]      r_dvld;

    logic signed [31:0] w_v [3];
    logic signed [31:0] w_e [3];
    logic signed [31:0] w_b [3];

    logic signed [63:0] r1_pb [3];
    logic signed [63:0] r1_pe [3];
    logic signed [31:0] r1_v [3];
    logic               r1_last;

    logic signed [31:0] r2_s [3];
    logic signed [31:0] r2_t [3];
    logic signed [31:0] r2_v [3];
    logic               r2_last;

    logic signed [63:0] r3_ts [3];
    logic signed [63:0] r3_ss [3];
    logic signed [63:0] r3_cp [3];
    logic signed [63:0] r3_cm [3];
    logic signed [31:0] r3_s [3];
    logic signed [31:0] r3_t [3];
    logic signed [31:0] r3_v [3];
    logic               r3_last;

    logic signed [31:0] r4_d;
    logic [DW-1:0]      r4_den;
    logic signed [52:0] r4_np [3];
    logic signed [31:0] r4_s [3];
    logic signed [31:0] r4_v [3];
    logic               r4_last;

    logic signed [63:0] r5_ds [3];
    logic [DW-1:0]      r5_den;
    logic signed [52:0] r5_np [3];
    logic signed [31:0] r5_v [3];
    logic               r5_last;

    logic [QB-1:0]      r6_mag [3];
    logic               r6_neg [3];
    logic [DW-1:0]      r6_den;
    logic signed [31:0] r6_v [3];
    logic               r6_last;

    logic signed [31:0] r_dv [QB][3];
    logic               r_dneg [QB][3];
    logic               r_dlast [QB];

    logic [QB-1:0]      w_quo [3];
    logic signed [52:0] n_fin [3];
    logic signed [52:0] n_np [3];
    logic signed [52:0] n_nn [3];

    logic               r_out_vld;
    vip_pkg::t_out_item r_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_out_vld;
    assign o_result    = r_out;

    assign w_v[0] = i_item.vel_x;
    assign w_v[1] = i_item.vel_y;
    assign w_v[2] = i_item.vel_z;
    assign w_e[0] = i_item.efield_x;
    assign w_e[1] = i_item.efield_y;
    assign w_e[2] = i_item.efield_z;
    assign w_b[0] = i_item.bfield_x;
    assign w_b[1] = i_item.bfield_y;
    assign w_b[2] = i_item.bfield_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta    <= '0;
            r_vld     <= '0;
            r_dvld    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_beta <= i_cfg_data;
            end
            r_vld     <= {r_vld[4:0], start};
            r_dvld    <= {r_dvld[QB-2:0], r_vld[5]};
            r_out_vld <= r_dvld[QB-1];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_np[i] = 53'(r3_t[i]) + 53'(vip_pkg::rnd(r3_cp[i]))
                    - 53'(vip_pkg::rnd(r3_cm[i]));
            n_nn[i] = r5_np[i] + 53'(vip_pkg::rnd(r5_ds[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_pb[i] <= r_beta * w_b[i];
            r1_pe[i] <= r_beta * w_e[i];
            r1_v[i]  <= w_v[i];

            r2_s[i] <= vip_pkg::sat32(53'(vip_pkg::rnd(r1_pb[i])));
            r2_t[i] <= vip_pkg::sat32(53'(r1_v[i]) + 53'(vip_pkg::rnd(r1_pe[i])));
            r2_v[i] <= r1_v[i];

            r3_ts[i] <= r2_t[i] * r2_s[i];
            r3_ss[i] <= r2_s[i] * r2_s[i];
            r3_s[i]  <= r2_s[i];
            r3_t[i]  <= r2_t[i];
            r3_v[i]  <= r2_v[i];

            r4_np[i] <= n_np[i];
            r4_s[i]  <= r3_s[i];
            r4_v[i]  <= r3_v[i];

            r5_ds[i] <= r4_d * r4_s[i];
            r5_np[i] <= r4_np[i];
            r5_v[i]  <= r4_v[i];

            r6_neg[i] <= n_nn[i][52];
            r6_mag[i] <= n_nn[i][52] ? QB'(-n_nn[i]) : QB'(n_nn[i]);
            r6_v[i]   <= r5_v[i];
        end
        r3_cp[0] <= r2_t[1] * r2_s[2];
        r3_cm[0] <= r2_t[2] * r2_s[1];
        r3_cp[1] <= r2_t[2] * r2_s[0];
        r3_cm[1] <= r2_t[0] * r2_s[2];
        r3_cp[2] <= r2_t[0] * r2_s[1];
        r3_cm[2] <= r2_t[1] * r2_s[0];

        r4_d   <= vip_pkg::sat32(53'(vip_pkg::rnd(r3_ts[0])) + 53'(vip_pkg::rnd(r3_ts[1]))
                                 + 53'(vip_pkg::rnd(r3_ts[2])));
        r4_den <= DW'(53'sd65536 + 53'(vip_pkg::rnd(r3_ss[0]))
                      + 53'(vip_pkg::rnd(r3_ss[1])) + 53'(vip_pkg::rnd(r3_ss[2])));
        r5_den <= r4_den;
        r6_den <= r5_den;

        r1_last <= i_item.batch_end;
        r2_last <= r1_last;
        r3_last <= r2_last;
        r4_last <= r3_last;
        r5_last <= r4_last;
        r6_last <= r5_last;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QB; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0) begin
                    r_dv[k][i]   <= r6_v[i];
                    r_dneg[k][i] <= r6_neg[i];
                end else begin
                    r_dv[k][i]   <= r_dv[k-1][i];
                    r_dneg[k][i] <= r_dneg[k-1][i];
                end
            end
            r_dlast[k] <= (k == 0) ? r6_last : r_dlast[(k == 0) ? 0 : k-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            vip_qdiv u_qdiv (
                .i_clk (i_clk),
                .i_mag (r6_mag[g]),
                .i_den (r6_den),
                .o_quo (w_quo[g])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_fin[i] = r_dneg[QB-1][i] ? -$signed(53'(w_quo[i])) : $signed(53'(w_quo[i]));
            n_fin[i] = (n_fin[i] <<< 1) - 53'(r_dv[QB-1][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.new_vel_x <= vip_pkg::sat32(n_fin[0]);
        r_out.new_vel_y <= vip_pkg::sat32(n_fin[1]);
        r_out.new_vel_z <= vip_pkg::sat32(n_fin[2]);
        r_out.last_out  <= r_dlast[QB-1];
        r_out.saturated <= (n_fin[0] != 53'(vip_pkg::sat32(n_fin[0])))
                        || (n_fin[1] != 53'(vip_pkg::sat32(n_fin[1])))
                        || (n_fin[2] != 53'(vip_pkg::sat32(n_fin[2])));
    end

endmodule

// ===== verif/tb.sv =====
module tb;

    typedef logic signed [95:0] t_wide;

    class t_velocity_scoreboard;
        vip_pkg::t_out_item expected_vel[$];
        int mismatches;

        function t_wide q_rnd(t_wide p);
            return (p + 96'sd32768) >>> 16;
        endfunction

        function t_wide q_sat(t_wide x, inout bit clip);
            if (x > 96'sd2147483647) begin
                clip = 1;
                return 96'sd2147483647;
            end else if (x < -96'sd2147483648) begin
                clip = 1;
                return -96'sd2147483648;
            end
            return x;
        endfunction

        function vip_pkg::t_out_item push_velocity(vip_pkg::t_in_item it,
                                                   logic signed [31:0] beta);
            t_wide v[3], e[3], b[3], s[3], t[3], n[3], r[3];
            t_wide bw, d, den, mag, q, vbar;
            bit dummy, clip;
            vip_pkg::t_out_item res;
            dummy = 0;
            clip = 0;
            bw = beta;
            v[0] = $signed(it.vel_x);
            v[1] = $signed(it.vel_y);
            v[2] = $signed(it.vel_z);
            e[0] = $signed(it.efield_x);
            e[1] = $signed(it.efield_y);
            e[2] = $signed(it.efield_z);
            b[0] = $signed(it.bfield_x);
            b[1] = $signed(it.bfield_y);
            b[2] = $signed(it.bfield_z);
            for (int i = 0; i < 3; i++) begin
                s[i] = q_sat(q_rnd(bw * b[i]), dummy);
                t[i] = q_sat(v[i] + q_rnd(bw * e[i]), dummy);
            end
            d = q_sat(q_rnd(t[0] * s[0]) + q_rnd(t[1] * s[1]) + q_rnd(t[2] * s[2]), dummy);
            den = 96'sd65536 + q_rnd(s[0] * s[0]) + q_rnd(s[1] * s[1]) + q_rnd(s[2] * s[2]);
            n[0] = t[0] + q_rnd(t[1] * s[2]) - q_rnd(t[2] * s[1]) + q_rnd(d * s[0]);
            n[1] = t[1] + q_rnd(t[2] * s[0]) - q_rnd(t[0] * s[2]) + q_rnd(d * s[1]);
            n[2] = t[2] + q_rnd(t[0] * s[1]) - q_rnd(t[1] * s[0]) + q_rnd(d * s[2]);
            for (int i = 0; i < 3; i++) begin
                mag = (n[i] < 0) ? -n[i] : n[i];
                q = (mag <<< 16) / den;
                vbar = (n[i] < 0) ? -q : q;
                r[i] = q_sat(2 * vbar - v[i], clip);
            end
            res.new_vel_x = r[0][31:0];
            res.new_vel_y = r[1][31:0];
            res.new_vel_z = r[2][31:0];
            res.last_out = it.batch_end;
            res.saturated = clip;
            return res;
        endfunction

        function void note_particle(vip_pkg::t_in_item it, logic signed [31:0] beta);
            expected_vel = {expected_vel, push_velocity(it, beta)};
        endfunction

        function void check_velocity(vip_pkg::t_out_item got);
            vip_pkg::t_out_item want;
            if (expected_vel.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result %h", got);
                end
                return;
            end
            want = expected_vel.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: expected x=%h y=%h z=%h last=%b sat=%b",
                             want.new_vel_x, want.new_vel_y, want.new_vel_z,
                             want.last_out, want.saturated);
                    $display("          actual   x=%h y=%h z=%h last=%b sat=%b",
                             got.new_vel_x, got.new_vel_y, got.new_vel_z,
                             got.last_out, got.saturated);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    vip_pkg::t_in_item i_item;
    logic o_strobe;
    vip_pkg::t_out_item o_result;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [31:0] i_cfg_data;

    t_velocity_scoreboard sb;
    logic signed [31:0] beta_now;
    int cycles;

    localparam int LATENCY = 60;
    localparam int CYCLE_LIMIT = 300000;

    implicit_particle_velocity_push_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_velocity(o_result);
        end
    end

    function automatic logic [31:0] rand_field(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic vip_pkg::t_in_item rand_particle();
        vip_pkg::t_in_item it;
        int mode;
        mode = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
        it.vel_x = rand_field(mode);
        it.vel_y = rand_field(mode);
        it.vel_z = rand_field(mode);
        it.efield_x = rand_field(mode);
        it.efield_y = rand_field(mode);
        it.efield_z = rand_field(mode);
        it.bfield_x = rand_field(mode);
        it.bfield_y = rand_field(mode);
        it.bfield_z = rand_field(mode);
        it.batch_end = $urandom_range(0, 7) == 0;
        return it;
    endfunction

    function automatic vip_pkg::t_in_item fill_particle(logic [31:0] v, logic [31:0] e,
                                                        logic [31:0] b, logic last);
        vip_pkg::t_in_item it;
        it.vel_x = v;
        it.vel_y = v;
        it.vel_z = v;
        it.efield_x = e;
        it.efield_y = e;
        it.efield_z = e;
        it.bfield_x = b;
        it.bfield_y = b;
        it.bfield_z = b;
        it.batch_end = last;
        return it;
    endfunction

    task automatic drain();
        while (sb.expected_vel.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_beta(logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        beta_now = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_particle(vip_pkg::t_in_item it, bit allow_idle);
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        sb.note_particle(it, beta_now);
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    logic [31:0] betas[8];

    initial begin
        sb = new();
        cycles = 0;
        beta_now = 0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        betas[0] = 32'h0000_0000;
        betas[1] = 32'h0001_0000;
        betas[2] = 32'h0000_8000;
        betas[3] = 32'hFFFF_B333;
        betas[4] = 32'h7FFF_FFFF;
        betas[5] = 32'h8000_0000;
        betas[6] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        betas[7] = 32'h0000_0400;

        for (int ph = 0; ph < 8; ph++) begin
            write_beta(betas[ph]);
            if (ph < 2) begin
                send_particle(fill_particle('0, '0, '0, 1'b0), 1'b0);
                send_particle(fill_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                            32'h7FFF_FFFF, 1'b1), 1'b0);
                send_particle(fill_particle(32'h8000_0000, 32'h8000_0000,
                                            32'h8000_0000, 1'b0), 1'b0);
                send_particle(fill_particle(32'h7FFF_FFFF, 32'h8000_0000,
                                            32'h7FFF_FFFF, 1'b1), 1'b0);
                send_particle(fill_particle(32'h0001_0000, '0, 32'h0001_0000, 1'b0), 1'b0);
                send_particle(fill_particle(32'hFFFF_0000, 32'h0002_0000, '0, 1'b1), 1'b0);
                send_particle(fill_particle(32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b0), 1'b0);
                send_particle(fill_particle(32'hFFFF_FFFF, 32'h0000_0001,
                                            32'hFFFF_FFFF, 1'b1), 1'b0);
            end
            for (int k = 0; k < 107; k++) begin
                send_particle(rand_particle(), ph < 7);
                if (ph == 3 && k == 50) begin
                    start <= 1'b0;
                    while (sb.expected_vel.size() != 0) begin
                        @(posedge i_clk);
                    end
                end
            end
            stop_sending();
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
